// ===== sv/acpu_pkg.sv =====
// Shared types, field positions and codes of the accumulator CPU execute block.
package acpu_pkg;

    // Data memory geometry
    localparam int unsigned DATA_WORDS = 65536;
    localparam int unsigned ADDR_W     = $clog2(DATA_WORDS);

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Instruction bit positions
    localparam int unsigned BIT_ALU   = 15;
    localparam int unsigned BIT_DUMP  = 14;
    localparam int unsigned BIT_CHAR  = 13;
    localparam int unsigned BIT_MEM   = 12;
    localparam int unsigned BIT_ARITH = 10;
    localparam int unsigned BIT_P0    = 9;
    localparam int unsigned BIT_P1    = 8;
    localparam int unsigned BIT_ZERO  = 7;
    localparam int unsigned BIT_SWAP  = 6;
    localparam int unsigned BIT_TO_A  = 5;
    localparam int unsigned BIT_TO_D  = 4;
    localparam int unsigned BIT_TO_M  = 3;
    localparam int unsigned BIT_JLT   = 2;
    localparam int unsigned BIT_JEQ   = 1;
    localparam int unsigned BIT_JGT   = 0;

    localparam logic [WORD_W-1:0] CHAR_LIMIT = 16'd128;

    // Instruction classes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DUMP = 2'd1;
    localparam logic [1:0] OP_ALU  = 2'd2;

    // Dump kinds
    localparam logic [1:0] DUMP_NONE = 2'd0;
    localparam logic [1:0] DUMP_NUM  = 2'd1;
    localparam logic [1:0] DUMP_CHAR = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] word;
    } op_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic [WORD_W-1:0] next_pc;
        logic              jump_taken;
        logic [1:0]        dump_kind;
        logic [WORD_W-1:0] dump_value;
    } result_t;

endpackage

// ===== sv/acpu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acpu_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/acpu_front.sv =====
// Front end: accepts instruction words and classifies them.
module acpu_front import acpu_pkg::*; (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,
    input  logic              mem_clearing,
    input  logic              queue_full,
    output logic              push,
    output op_t               push_op
);

    assign s_tready = !queue_full && !mem_clearing;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        push_op.word = s_tdata;
        if (!s_tdata[BIT_ALU]) begin
            push_op.kind = OP_LOAD;
        end else if (s_tdata[BIT_DUMP]) begin
            push_op.kind = OP_DUMP;
        end else begin
            push_op.kind = OP_ALU;
        end
    end

endmodule

// ===== sv/acpu_queue.sv =====
// Short FIFO of decoded instructions between front and back end.
module acpu_queue import acpu_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head_op,
    output logic empty,
    output logic full
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== sv/acpu_back.sv =====
// Back end: operand fetch, ALU execute, register/memory update, result register.
module acpu_back import acpu_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              queue_empty,
    input  op_t               head_op,
    output logic              pop,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [WORD_W-1:0] rd_data,
    output mem_wr_t           mem_wr,
    output logic              m_tvalid,
    input  logic              m_tready,
    output result_t           m_result
);

    logic              stage_valid_reg, stage_valid_next;
    op_t               stage_op_reg;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] d_reg, d_next;
    logic [WORD_W-1:0] r_reg, r_next;
    logic [WORD_W-1:0] pc_reg, pc_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic              exec;

    assign pop     = !stage_valid_reg && !queue_empty;
    assign rd_en   = pop;
    assign rd_addr = a_reg[ADDR_W-1:0];
    assign exec    = stage_valid_reg && (!out_valid_reg || m_tready);

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;

    always_comb begin
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] v1, v2, tmp, res;
        logic              jump;

        w      = stage_op_reg.word;
        v1     = d_reg;
        v2     = w[BIT_MEM] ? rd_data : a_reg;
        tmp    = '0;
        res    = '0;
        jump   = 1'b0;
        a_next = a_reg;
        d_next = d_reg;
        r_next = r_reg;
        pc_next = pc_reg;
        mem_wr  = '0;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        stage_valid_next = stage_valid_reg;

        if (w[BIT_SWAP]) begin
            tmp = v1;
            v1  = v2;
            v2  = tmp;
        end
        if (w[BIT_ZERO]) begin
            v1 = '0;
        end
        if (w[BIT_ARITH]) begin
            if (w[BIT_P0]) begin
                v2 = WORD_W'(1);
            end
            res = w[BIT_P1] ? v1 - v2 : v1 + v2;
        end else begin
            case ({w[BIT_P0], w[BIT_P1]})
                2'b11:   res = ~v1;
                2'b01:   res = v1 ^ v2;
                2'b10:   res = v1 | v2;
                default: res = v1 & v2;
            endcase
        end

        if (pop) begin
            stage_valid_next = 1'b1;
        end

        if (exec) begin
            stage_valid_next = 1'b0;
            out_valid_next   = 1'b1;
            out_next.dump_kind  = DUMP_NONE;
            out_next.dump_value = '0;
            unique case (stage_op_reg.kind)
                OP_LOAD: begin
                    a_next = w;
                end
                OP_DUMP: begin
                    out_next.dump_value = a_reg;
                    out_next.dump_kind  = (w[BIT_CHAR] && a_reg < CHAR_LIMIT) ?
                                          DUMP_CHAR : DUMP_NUM;
                end
                OP_ALU: begin
                    if (w[BIT_TO_A]) begin
                        a_next = res;
                    end
                    if (w[BIT_TO_D]) begin
                        d_next = res;
                    end
                    mem_wr.en   = w[BIT_TO_M];
                    mem_wr.addr = a_next[ADDR_W-1:0];
                    mem_wr.data = res;
                    r_next = res;
                    jump = (w[BIT_JEQ] && res == '0) ||
                           (w[BIT_JLT] && res[WORD_W-1]) ||
                           (w[BIT_JGT] && !res[WORD_W-1] && res != '0);
                end
                default: begin
                end
            endcase
            pc_next = jump ? a_next : pc_reg + 1'b1;
            out_next.result_value = r_next;
            out_next.next_pc      = pc_next;
            out_next.jump_taken   = jump;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            a_reg  <= '0;
            d_reg  <= '0;
            r_reg  <= '0;
            pc_reg <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            a_reg  <= a_next;
            d_reg  <= d_next;
            r_reg  <= r_next;
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            stage_op_reg <= head_op;
        end
        out_reg <= out_next;
    end

endmodule

// ===== sv/accumulator_cpu_execute_top.sv =====
// Top level of the accumulator CPU execute block: front end, queue, back end, data memory.
// Path: an accepted word is written into the queue, then its operand is read, then it executes
//   into the output register, from which its result word is given out.
// Flow: the back end takes no new word while one waits in its stage; it reads memory[A] before it
//   executes, because A may have been changed by the instruction just before.
// Reset: A, D, R and pc clear at once; the data memory is then cleared by a pass over its
//   DATA_WORDS (65536) words, during which s_tready stays low.
module accumulator_cpu_execute_top import acpu_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] instruction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [15:0] result_value, [31:16] next_pc, [47:32] dump_value
    output logic [2:0]  m_tuser     // [0] jump_taken, [2:1] dump_kind
);

    // Front/back handoff
    logic        push, pop, q_empty, q_full;
    op_t         push_op, head_op;

    // Memory ports
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    mem_wr_t           back_wr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    // Clearing pass after reset
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    result_t           result;

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DATA_WORDS - 1)) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // Back end is idle while clearing, so the write port is simply shared
    assign ram_we    = clearing_reg || back_wr.en;
    assign ram_waddr = clearing_reg ? clr_addr_reg : back_wr.addr;
    assign ram_wdata = clearing_reg ? '0 : back_wr.data;

    acpu_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .mem_clearing (clearing_reg),
        .queue_full   (q_full),
        .push         (push),
        .push_op      (push_op)
    );

    acpu_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    acpu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DATA_WORDS)
    ) u_dmem (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    acpu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (q_empty),
        .head_op     (head_op),
        .pop         (pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .mem_wr      (back_wr),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_result    (result)
    );

    assign m_tdata = {result.dump_value, result.next_pc, result.result_value};
    assign m_tuser = {result.dump_kind, result.jump_taken};

endmodule

// ===== sim/accumulator_cpu_execute_top_tb.sv =====
// Self-checking testbench for the accumulator CPU execute block: directed and random programs.
module accumulator_cpu_execute_top_tb;
    import acpu_pkg::*;

    // Reset holds s_tready low while the data memory is cleared, so the limit covers that pass.
    localparam int unsigned IDLE_LIMIT   = 4 * DATA_WORDS + 20000;
    localparam int unsigned RANDOM_WORDS = 200;

    // Instruction bit masks
    localparam logic [15:0] I_ALU   = 16'h1 << BIT_ALU;
    localparam logic [15:0] I_DUMP  = 16'h1 << BIT_DUMP;
    localparam logic [15:0] I_CHAR  = 16'h1 << BIT_CHAR;
    localparam logic [15:0] I_MEM   = 16'h1 << BIT_MEM;
    localparam logic [15:0] I_SPARE = 16'h1 << 11;
    localparam logic [15:0] I_ARITH = 16'h1 << BIT_ARITH;
    localparam logic [15:0] I_P0    = 16'h1 << BIT_P0;
    localparam logic [15:0] I_P1    = 16'h1 << BIT_P1;
    localparam logic [15:0] I_ZERO  = 16'h1 << BIT_ZERO;
    localparam logic [15:0] I_SWAP  = 16'h1 << BIT_SWAP;
    localparam logic [15:0] I_TO_A  = 16'h1 << BIT_TO_A;
    localparam logic [15:0] I_TO_D  = 16'h1 << BIT_TO_D;
    localparam logic [15:0] I_TO_M  = 16'h1 << BIT_TO_M;
    localparam logic [15:0] I_JLT   = 16'h1 << BIT_JLT;
    localparam logic [15:0] I_JEQ   = 16'h1 << BIT_JEQ;
    localparam logic [15:0] I_JGT   = 16'h1 << BIT_JGT;

    // Logic unit select, written as {P0, P1}
    localparam logic [1:0] LOGIC_AND = 2'b00;
    localparam logic [1:0] LOGIC_XOR = 2'b01;
    localparam logic [1:0] LOGIC_OR  = 2'b10;
    localparam logic [1:0] LOGIC_NOT = 2'b11;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;    // [15:0] result_value, [31:16] next_pc, [47:32] dump_value
    logic [2:0]  m_tuser;    // [0] jump_taken, [2:1] dump_kind

    // Mirror of the CPU state
    logic [15:0] cpu_a, cpu_d, cpu_r, cpu_pc;
    logic [15:0] data_mem [DATA_WORDS];

    result_t     awaited_results[$];
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned fail_count     = 0;
    int unsigned words_sent     = 0;
    int unsigned words_checked  = 0;
    int unsigned jumps_seen     = 0;
    int unsigned dumps_seen     = 0;
    int unsigned idle_cycles    = 0;

    accumulator_cpu_execute_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // ALU output from the current D, A and memory[A]
    function automatic logic [15:0] alu_out(input logic [15:0] w);
        logic [15:0] v1;
        logic [15:0] v2;
        logic [15:0] t;
        v1 = cpu_d;
        v2 = w[BIT_MEM] ? data_mem[cpu_a % DATA_WORDS] : cpu_a;
        if (w[BIT_SWAP]) begin
            t  = v1;
            v1 = v2;
            v2 = t;
        end
        if (w[BIT_ZERO])
            v1 = '0;
        if (w[BIT_ARITH]) begin
            if (w[BIT_P0])
                v2 = 16'd1;
            return w[BIT_P1] ? v1 - v2 : v1 + v2;
        end
        case ({w[BIT_P0], w[BIT_P1]})
            LOGIC_NOT: begin
                return ~v1;
            end
            LOGIC_XOR: begin
                return v1 ^ v2;
            end
            LOGIC_OR: begin
                return v1 | v2;
            end
            default: begin
                return v1 & v2;
            end
        endcase
    endfunction

    // Execute one instruction on the mirror and queue the result word it should give
    task automatic execute_instruction(input logic [15:0] w);
        result_t            res;
        logic [15:0]        r;
        logic signed [15:0] sr;
        logic               jump;
        jump = 1'b0;
        res  = '0;
        if (!w[BIT_ALU]) begin
            cpu_a = w;
        end else if (w[BIT_DUMP]) begin
            res.dump_value = cpu_a;
            res.dump_kind  = (w[BIT_CHAR] && cpu_a < CHAR_LIMIT) ? DUMP_CHAR : DUMP_NUM;
        end else begin
            r = alu_out(w);
            // stores in order A, D, memory; memory uses the new A
            if (w[BIT_TO_A])
                cpu_a = r;
            if (w[BIT_TO_D])
                cpu_d = r;
            if (w[BIT_TO_M])
                data_mem[cpu_a % DATA_WORDS] = r;
            cpu_r = r;
            sr    = r;
            jump  = (w[BIT_JLT] && sr < 0) || (w[BIT_JEQ] && sr == 0) ||
                    (w[BIT_JGT] && sr > 0);
        end
        cpu_pc = jump ? cpu_a : cpu_pc + 16'd1;
        res.result_value = cpu_r;
        res.next_pc      = cpu_pc;
        res.jump_taken   = jump;
        awaited_results.push_back(res);
    endtask

    // Offer one word, idling first at random, and return once it is accepted
    task automatic send_instruction(input logic [15:0] w);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        execute_instruction(w);
        words_sent++;
    endtask

    // Random instruction: mostly loads to a few addresses, ALU words and dumps
    function automatic logic [15:0] random_instruction();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(9) < 7)
                return 16'($urandom_range(31));
            return {1'b0, 15'($urandom)};
        end
        if (pick < 35)
            return I_ALU | I_DUMP | 16'($urandom_range(16'h3fff));
        if (pick < 92)
            return I_ALU | 16'($urandom_range(16'h3fff));
        return 16'($urandom);
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count)
            send_instruction(random_instruction());
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_instruction(16'h0000);                          // load, lowest word
        send_instruction(16'h7fff);                          // load, highest word
        send_instruction(I_ALU | I_DUMP);                    // number dump
        send_instruction(I_ALU | I_DUMP | I_CHAR);           // char dump, A too large
        send_instruction(16'd127);
        send_instruction(I_ALU | I_DUMP | I_CHAR);           // char dump, A just fits
        send_instruction(16'd128);
        send_instruction(I_ALU | I_DUMP | I_CHAR);           // char dump at the limit
        // D = A + 1 (increment)
        send_instruction(I_ALU | I_ARITH | I_P0 | I_SWAP | I_TO_D);
        // memory[A] = D + A
        send_instruction(I_ALU | I_ARITH | I_TO_M);
        // D = D - memory[A], negative, jump if below zero
        send_instruction(I_ALU | I_MEM | I_ARITH | I_P1 | I_TO_D | I_JLT);
        send_instruction(I_ALU | LOGIC_AND << BIT_P1 | I_TO_D | I_JEQ);
        send_instruction(I_ALU | I_P0 | I_JGT);              // OR
        send_instruction(I_ALU | I_P1 | I_TO_D | I_JEQ);     // XOR to zero
        // A = NOT 0, jump to 0xffff
        send_instruction(I_ALU | I_P0 | I_P1 | I_ZERO | I_TO_A | I_JLT);
        // A = A - 1 then memory at the new A; spare and char bits set; pc wraps
        send_instruction(I_ALU | I_ARITH | I_P0 | I_P1 | I_SWAP | I_TO_A | I_TO_M |
                         I_SPARE | I_CHAR);
        send_instruction(I_ALU | I_MEM | I_ARITH | I_SWAP | I_TO_D);
        send_instruction(16'd5);
        // read of a cleared word, all jump conditions on
        send_instruction(I_ALU | I_MEM | I_P0 | I_SWAP | I_JLT | I_JEQ | I_JGT);
        send_instruction(I_ALU | I_DUMP | I_CHAR);
        send_instruction(I_ALU | I_ARITH | I_P1 | I_ZERO | I_TO_D);   // 0 - A
    endtask

    task automatic test_random_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(RANDOM_WORDS);
    endtask

    task automatic test_random_src_idle();
        src_idle_pct   = 63;
        sink_stall_pct = 0;
        run_random(RANDOM_WORDS);
    endtask

    task automatic test_random_sink_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 63;
        run_random(RANDOM_WORDS);
    endtask

    task automatic test_random_both_idle();
        src_idle_pct   = 23;
        sink_stall_pct = 23;
        run_random(RANDOM_WORDS);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Receiver: random stall, one assignment per edge
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // Result checker and watchdog
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t unexpected result word %h / %h", $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_value", want.result_value, m_tdata[15:0]);
                check_field("next_pc", want.next_pc, m_tdata[31:16]);
                check_field("dump_value", want.dump_value, m_tdata[47:32]);
                check_field("jump_taken", 16'(want.jump_taken), 16'(m_tuser[0]));
                check_field("dump_kind", 16'(want.dump_kind), 16'(m_tuser[2:1]));
                if (want.jump_taken)
                    jumps_seen++;
                if (want.dump_kind != DUMP_NONE)
                    dumps_seen++;
                words_checked++;
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout, %0d results outstanding", $time, awaited_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cpu_a  = '0;
        cpu_d  = '0;
        cpu_r  = '0;
        cpu_pc = '0;
        foreach (data_mem[i])
            data_mem[i] = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_no_idle();
        test_random_src_idle();
        test_random_sink_stall();
        test_random_both_idle();

        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d instructions in four idle/stall phases, %0d results checked",
                 words_sent, words_checked);
        $display("results with a taken jump: %0d, with a dump: %0d", jumps_seen, dumps_seen);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
